FILE: hdl/tcw_pkg.sv
// ----------------------------------------------------------------------------
// tcw_pkg: text console character writer, shared definitions
// Field widths, item layouts and function codes of the console.
// ----------------------------------------------------------------------------
package tcw_pkg;

  localparam int unsigned FUNC_W      = 2;
  localparam int unsigned CHAR_W      = 8;
  localparam int unsigned ATTR_W      = 8;
  localparam int unsigned ROW_FIELD_W = 5;
  localparam int unsigned COL_FIELD_W = 7;
  localparam int unsigned CELL_W      = CHAR_W + ATTR_W;

  localparam int unsigned IN_FIELDS_W  = FUNC_W + CHAR_W + ROW_FIELD_W + COL_FIELD_W;
  localparam int unsigned IN_DATA_W    = ((IN_FIELDS_W + 7) / 8) * 8;
  localparam int unsigned OUT_FIELDS_W = CELL_W + ROW_FIELD_W + COL_FIELD_W;
  localparam int unsigned OUT_DATA_W   = ((OUT_FIELDS_W + 7) / 8) * 8;

  localparam logic [FUNC_W-1:0] FUNC_PUT   = 2'd0;
  localparam logic [FUNC_W-1:0] FUNC_READ  = 2'd1;
  localparam logic [FUNC_W-1:0] FUNC_CLEAR = 2'd2;

  localparam logic [CHAR_W-1:0] NEWLINE_CODE = 8'h0A;
  localparam logic [CHAR_W-1:0] SPACE_CODE   = 8'h20;
  localparam logic [ATTR_W-1:0] ATTR_RESET   = 8'h0F;

  typedef struct packed {
    logic [COL_FIELD_W-1:0] read_col;
    logic [ROW_FIELD_W-1:0] read_row;
    logic [CHAR_W-1:0]      char_code;
    logic [FUNC_W-1:0]      func;
  } in_item_t;

  typedef struct packed {
    logic [COL_FIELD_W-1:0] cursor_col;
    logic [ROW_FIELD_W-1:0] cursor_row;
    logic [CELL_W-1:0]      cell_value;
  } out_item_t;

endpackage

FILE: hdl/text_console_char_writer_top.sv
// ----------------------------------------------------------------------------
// text_console_char_writer_top: character-cell text console
// Screen store of ROWS x COLUMNS cells (character low byte, attribute high
// byte) with a cursor; put, read and clear items under a small sequencer.
//
//   channel  dir  handshake                 payload
//   s_axis   in   s_axis_tvalid/tready      tdata: func, char_code, read_row, read_col
//   m_axis   out  m_axis_tvalid/tready      tdata: cell_value, cursor_row, cursor_col
//   cfg      in   cfg_valid_i/cfg_ready_o   cfg_data_i: color_attribute
//
// A read outside the screen skips the store and returns a zero cell. A
// newline or wrap on the bottom row scrolls: each cell is read one row
// down and written back through the single store port pair, then the
// bottom row is blanked. After reset a clearing pass runs with
// s_axis_tready low. One item at a time; the output register lets the
// next item in while a result waits.
// ----------------------------------------------------------------------------
module text_console_char_writer_top #(
  parameter int unsigned COLUMNS = 80,
  parameter int unsigned ROWS    = 25
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  // func [1:0], char_code [9:2], read_row [14:10], read_col [21:15]
  input  logic [tcw_pkg::IN_DATA_W-1:0]  s_axis_tdata,
  input  logic                           s_axis_tvalid,
  output logic                           s_axis_tready,
  // cell_value [15:0], cursor_row [20:16], cursor_col [27:21]
  output logic [tcw_pkg::OUT_DATA_W-1:0] m_axis_tdata,
  output logic                           m_axis_tvalid,
  input  logic                           m_axis_tready,
  input  logic                           cfg_valid_i,
  output logic                           cfg_ready_o,
  input  logic [tcw_pkg::ATTR_W-1:0]     cfg_data_i
);

  localparam int unsigned CELLS     = ROWS * COLUMNS;
  localparam int unsigned AW        = $clog2(CELLS);
  localparam int unsigned RW        = $clog2(ROWS);
  localparam int unsigned CW        = $clog2(COLUMNS);
  localparam int unsigned LAST_BASE = (ROWS - 1) * COLUMNS;

  localparam logic [AW-1:0] IDX_LAST      = AW'(CELLS - 1);
  localparam logic [AW-1:0] IDX_SCR_LAST  = AW'(LAST_BASE - 1);
  localparam logic [AW-1:0] IDX_LAST_BASE = AW'(LAST_BASE);
  localparam logic [RW-1:0] ROW_LAST      = RW'(ROWS - 1);
  localparam logic [CW-1:0] COL_LAST      = CW'(COLUMNS - 1);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_RD_WAIT,
    ST_SCR_RD,
    ST_SCR_WR,
    ST_FILL,
    ST_DONE
  } state_e;

  state_e                         state_q, state_d;
  logic [AW-1:0]                  idx_q, idx_d;
  logic [RW-1:0]                  row_q, row_d;
  logic [CW-1:0]                  col_q, col_d;
  logic [tcw_pkg::CELL_W-1:0]     blank_q, blank_d;
  logic [tcw_pkg::CELL_W-1:0]     cell_q, cell_d;
  logic                           pend_q, pend_d;
  logic [tcw_pkg::ATTR_W-1:0]     attr_q;
  logic                           m_valid_q, m_valid_d;
  tcw_pkg::out_item_t             m_item_q, m_item_d;

  tcw_pkg::in_item_t              in_item;
  logic                           in_acc;
  logic                           rd_in_range;
  logic [AW-1:0]                  cur_addr;
  logic [AW-1:0]                  rd_addr;

  logic                           ram_we;
  logic [AW-1:0]                  ram_waddr;
  logic [tcw_pkg::CELL_W-1:0]     ram_wdata;
  logic [AW-1:0]                  ram_raddr;
  logic [tcw_pkg::CELL_W-1:0]     ram_rdata;

  tcw_ram #(
    .WIDTH (tcw_pkg::CELL_W),
    .DEPTH (CELLS)
  ) u_screen (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  assign in_item       = tcw_pkg::in_item_t'(s_axis_tdata[tcw_pkg::IN_FIELDS_W-1:0]);
  assign s_axis_tready = (state_q == ST_IDLE);
  assign in_acc        = s_axis_tvalid && s_axis_tready;
  assign cfg_ready_o   = 1'b1;

  assign rd_in_range = (int'(in_item.read_row) < ROWS) && (int'(in_item.read_col) < COLUMNS);
  assign cur_addr    = AW'(int'(row_q) * COLUMNS + int'(col_q));
  assign rd_addr     = AW'(int'(in_item.read_row) * COLUMNS + int'(in_item.read_col));

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = tcw_pkg::OUT_DATA_W'(m_item_q);

  always_comb begin
    state_d   = state_q;
    idx_d     = idx_q;
    row_d     = row_q;
    col_d     = col_q;
    blank_d   = blank_q;
    cell_d    = cell_q;
    pend_d    = pend_q;
    m_valid_d = m_valid_q;
    m_item_d  = m_item_q;
    ram_we    = 1'b0;
    ram_waddr = idx_q;
    ram_wdata = blank_q;
    ram_raddr = AW'(int'(idx_q) + COLUMNS);

    if (m_valid_q && m_axis_tready) begin
      m_valid_d = 1'b0;
    end

    unique case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          pend_d  = 1'b1;
          cell_d  = '0;
          state_d = ST_DONE;
          priority if (in_item.func == tcw_pkg::FUNC_PUT) begin
            if (in_item.char_code != tcw_pkg::NEWLINE_CODE) begin
              ram_we    = 1'b1;
              ram_waddr = cur_addr;
              ram_wdata = {attr_q, in_item.char_code};
            end
            if (in_item.char_code == tcw_pkg::NEWLINE_CODE || col_q == COL_LAST) begin
              col_d = '0;
              if (row_q != ROW_LAST) begin
                row_d = row_q + RW'(1);
              end else begin
                idx_d   = '0;
                state_d = ST_SCR_RD;
              end
            end else begin
              col_d = col_q + CW'(1);
            end
          end else if (in_item.func == tcw_pkg::FUNC_READ) begin
            ram_raddr = rd_addr;
            if (rd_in_range) begin
              state_d = ST_RD_WAIT;
            end
          end else if (in_item.func == tcw_pkg::FUNC_CLEAR) begin
            idx_d   = '0;
            row_d   = '0;
            col_d   = '0;
            blank_d = {attr_q, tcw_pkg::SPACE_CODE};
            state_d = ST_FILL;
          end else begin
            state_d = ST_DONE;
          end
        end
      end
      ST_RD_WAIT: begin
        cell_d  = ram_rdata;
        state_d = ST_DONE;
      end
      ST_SCR_RD: begin
        state_d = ST_SCR_WR;
      end
      ST_SCR_WR: begin
        ram_we    = 1'b1;
        ram_wdata = ram_rdata;
        if (idx_q == IDX_SCR_LAST) begin
          idx_d   = IDX_LAST_BASE;
          blank_d = {attr_q, tcw_pkg::SPACE_CODE};
          state_d = ST_FILL;
        end else begin
          idx_d   = idx_q + AW'(1);
          state_d = ST_SCR_RD;
        end
      end
      ST_FILL: begin
        ram_we = 1'b1;
        if (idx_q == IDX_LAST) begin
          state_d = pend_q ? ST_DONE : ST_IDLE;
        end else begin
          idx_d = idx_q + AW'(1);
        end
      end
      ST_DONE: begin
        if (!m_valid_q || m_axis_tready) begin
          m_valid_d           = 1'b1;
          m_item_d.cell_value = cell_q;
          m_item_d.cursor_row = tcw_pkg::ROW_FIELD_W'(row_q);
          m_item_d.cursor_col = tcw_pkg::COL_FIELD_W'(col_q);
          pend_d              = 1'b0;
          state_d             = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_FILL;
      idx_q     <= '0;
      row_q     <= '0;
      col_q     <= '0;
      blank_q   <= {tcw_pkg::ATTR_RESET, tcw_pkg::SPACE_CODE};
      cell_q    <= '0;
      pend_q    <= 1'b0;
      attr_q    <= tcw_pkg::ATTR_RESET;
      m_valid_q <= 1'b0;
      m_item_q  <= '0;
    end else begin
      state_q   <= state_d;
      idx_q     <= idx_d;
      row_q     <= row_d;
      col_q     <= col_d;
      blank_q   <= blank_d;
      cell_q    <= cell_d;
      pend_q    <= pend_d;
      m_valid_q <= m_valid_d;
      m_item_q  <= m_item_d;
      if (cfg_valid_i && cfg_ready_o) begin
        attr_q <= cfg_data_i;
      end
    end
  end

endmodule

FILE: hdl/tcw_ram.sv
// ----------------------------------------------------------------------------
// tcw_ram: generic simple dual-port RAM
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module tcw_ram #(
  parameter int unsigned WIDTH = 16,
  parameter int unsigned DEPTH = 2000
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule
